[sv/j2k_cal_pkg.sv]
// Package for the J2000 seconds / calendar converter.
// Request and response structs, sequencer states and the constants.
// No dependencies.
package j2k_cal_pkg;

   typedef struct packed {
      logic        kind;
      logic [31:0] seconds_in;
      logic [29:0] nanoseconds_in;
      logic [23:0] date_bcd;
      logic [21:0] time_bcd;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  year_offset;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic [31:0] seconds_out;
      logic [29:0] nanoseconds_out;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SET,      // time-of-day split and date steps, one per cycle
      ST_GET,      // get steps
      ST_DONE
   } state_type;

   localparam logic        KIND_SET    = 1'b0;
   localparam logic        KIND_GET    = 1'b1;
   localparam logic [29:0] NS_SHIFT    = 30'd184000000;
   localparam logic [31:0] SEC_TO_MIDN = 32'd43136;
   localparam logic [31:0] SEC_PER_DAY = 32'd86400;

   localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
   localparam logic [31:0] SEC_PER_MIN  = 32'd60;
   localparam logic [31:0] JD_Y2K       = 32'd2451545;
   localparam logic [31:0] JD_SHIFT     = 32'd68569;
   localparam logic [31:0] JD_BASE      = 32'd32075;
   localparam logic [31:0] DIV_CYCLE    = 32'd146097;
   localparam logic [31:0] DIV_YEAR     = 32'd1461001;
   localparam logic [31:0] DIV_MONTH    = 32'd2447;
   localparam logic [31:0] DIV_DAY      = 32'd80;
   localparam logic [31:0] DIV_MSEL     = 32'd11;
   localparam logic [31:0] DIV_MON12    = 32'd12;
   localparam logic [31:0] DIV_CENTURY  = 32'd100;

   // floor(2^32 / d): estimate is exact or one low for any 32-bit dividend
   localparam logic [31:0] RCP_DAY     = 32'((64'd1 << 32) / 64'd86400);
   localparam logic [31:0] RCP_HOUR    = 32'((64'd1 << 32) / 64'd3600);
   localparam logic [31:0] RCP_MIN     = 32'((64'd1 << 32) / 64'd60);
   localparam logic [31:0] RCP_CYCLE   = 32'((64'd1 << 32) / 64'd146097);
   localparam logic [31:0] RCP_YEAR    = 32'((64'd1 << 32) / 64'd1461001);
   localparam logic [31:0] RCP_MONTH   = 32'((64'd1 << 32) / 64'd2447);
   localparam logic [31:0] RCP_DAY80   = 32'((64'd1 << 32) / 64'd80);
   localparam logic [31:0] RCP_MSEL    = 32'((64'd1 << 32) / 64'd11);
   localparam logic [31:0] RCP_MON12   = 32'((64'd1 << 32) / 64'd12);
   localparam logic [31:0] RCP_CENTURY = 32'((64'd1 << 32) / 64'd100);

   localparam logic [5:0]  SET_LAST = 6'd35;
   localparam logic [5:0]  GET_LAST = 6'd13;

endpackage

[sv/j2000_seconds_calendar_converter_unit.sv]
// Top level of the J2000 seconds / calendar converter.
// Uses j2k_cal_pkg for payload structs, states and constants.
//
// Usage:
//   req_ channel carries one transaction: kind 0 sets the time from J2000
//   seconds and returns the calendar date; kind 1 turns BCD calendar words
//   into J2000 seconds (valid only after a set).
//   rsp_ channel returns exactly one transaction per request.
// Sequencing:
//   one shared 32x32 multiplier serves every multiply. Each constant division
//   is a reciprocal estimate, a multiply back and a one-step correction.
//   A set runs the set steps and a get the get steps before rsp_valid;
//   a refused set or a get before any set answers without the steps. The
//   block takes one request at a time: after the response is taken it
//   returns to idle, and req_ready is low meanwhile.
// Reset: synchronous, clears the sequencer and the time-valid flag.
// Stall: the result stays in the output register until rsp_ready; the
//   block takes no new request until then.
module j2000_seconds_calendar_converter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  j2k_cal_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output j2k_cal_pkg::rsp_type  rsp_data
);

   j2k_cal_pkg::state_type state_ff, state_in;
   logic        valid_ff, valid_in;
   logic [5:0]  cnt_ff, cnt_in;
   // divider: dividend, quotient estimate and remainder
   logic [31:0] x_ff, x_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   // general registers for the step sequence
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   j2k_cal_pkg::req_type req_ff, req_in;
   j2k_cal_pkg::rsp_type rsp_ff, rsp_in;

   // shared unit: a * b + c, full product kept for reciprocal estimates
   logic [31:0] mu_a, mu_b, mu_c, mu_lo;
   logic [63:0] mu_p;
   logic [31:0] dv_den, dv_rcp;

   always_comb begin
      mu_p  = {32'd0, mu_a} * {32'd0, mu_b};
      mu_lo = mu_p[31:0] + mu_c;
   end

   // BCD decode for get
   logic [31:0] g_year, g_mon, g_day, g_hour, g_min, g_sec, g_mshift, g_ycarry;
   logic        g_early;
   always_comb begin
      g_year = 32'(req_ff.date_bcd[23:20]) * 32'd10 + 32'(req_ff.date_bcd[19:16]) + 32'd2000;
      g_mon  = 32'(req_ff.date_bcd[12]) * 32'd10 + 32'(req_ff.date_bcd[11:8]);
      g_day  = 32'(req_ff.date_bcd[5:4]) * 32'd10 + 32'(req_ff.date_bcd[3:0]);
      g_hour = 32'(req_ff.time_bcd[21:20]) * 32'd10 + 32'(req_ff.time_bcd[19:16]);
      g_min  = 32'(req_ff.time_bcd[14:12]) * 32'd10 + 32'(req_ff.time_bcd[11:8]);
      g_sec  = 32'(req_ff.time_bcd[6:4]) * 32'd10 + 32'(req_ff.time_bcd[3:0]);
      // (month - 14) / 12 truncates to -1 for months 0..2, else 0
      g_early  = (g_mon < 32'd3);
      g_ycarry = {31'd0, g_early};
      g_mshift = g_early ? g_mon + 32'd10 : g_mon - 32'd2;
   end

   // divisor and reciprocal for the division running at this step
   always_comb begin
      dv_den = j2k_cal_pkg::SEC_PER_DAY;
      dv_rcp = j2k_cal_pkg::RCP_DAY;
      if (state_ff == j2k_cal_pkg::ST_SET) begin
         case (cnt_ff) inside
            [6'd4:6'd6]: begin
               dv_den = j2k_cal_pkg::SEC_PER_HOUR; dv_rcp = j2k_cal_pkg::RCP_HOUR; end
            [6'd8:6'd10]: begin
               dv_den = j2k_cal_pkg::SEC_PER_MIN; dv_rcp = j2k_cal_pkg::RCP_MIN; end
            [6'd12:6'd14]: begin
               dv_den = j2k_cal_pkg::DIV_CYCLE; dv_rcp = j2k_cal_pkg::RCP_CYCLE; end
            [6'd17:6'd19]: begin
               dv_den = j2k_cal_pkg::DIV_YEAR; dv_rcp = j2k_cal_pkg::RCP_YEAR; end
            [6'd22:6'd24]: begin
               dv_den = j2k_cal_pkg::DIV_MONTH; dv_rcp = j2k_cal_pkg::RCP_MONTH; end
            [6'd26:6'd28]: begin
               dv_den = j2k_cal_pkg::DIV_DAY; dv_rcp = j2k_cal_pkg::RCP_DAY80; end
            [6'd30:6'd32]: begin
               dv_den = j2k_cal_pkg::DIV_MSEL; dv_rcp = j2k_cal_pkg::RCP_MSEL; end
            default: begin
               dv_den = j2k_cal_pkg::SEC_PER_DAY; dv_rcp = j2k_cal_pkg::RCP_DAY; end
         endcase
      end else begin
         case (cnt_ff) inside
            [6'd6:6'd8]: begin
               dv_den = j2k_cal_pkg::DIV_CENTURY; dv_rcp = j2k_cal_pkg::RCP_CENTURY; end
            default: begin
               dv_den = j2k_cal_pkg::DIV_MON12; dv_rcp = j2k_cal_pkg::RCP_MON12; end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         j2k_cal_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.kind != j2k_cal_pkg::KIND_SET) state_in = j2k_cal_pkg::ST_GET;
               else if (req_data.seconds_in == 32'd0 &&
                        req_data.nanoseconds_in < j2k_cal_pkg::NS_SHIFT)
                  state_in = j2k_cal_pkg::ST_DONE;
               else state_in = j2k_cal_pkg::ST_SET;
            end
         end
         j2k_cal_pkg::ST_SET: if (cnt_ff == j2k_cal_pkg::SET_LAST) state_in = j2k_cal_pkg::ST_DONE;
         j2k_cal_pkg::ST_GET: begin
            if (!valid_ff || cnt_ff == j2k_cal_pkg::GET_LAST) state_in = j2k_cal_pkg::ST_DONE;
         end
         j2k_cal_pkg::ST_DONE: if (rsp_ready) state_in = j2k_cal_pkg::ST_IDLE;
         default: state_in = j2k_cal_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff + 6'd1;
      x_in     = x_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      mu_a = 32'd0; mu_b = 32'd0; mu_c = 32'd0;

      case (state_ff)
         j2k_cal_pkg::ST_IDLE: begin
            cnt_in = 6'd0;
            req_in = req_data;
            rsp_in = '0;
            if (req_data.nanoseconds_in < j2k_cal_pkg::NS_SHIFT)
               x_in = req_data.seconds_in - 32'd1 + j2k_cal_pkg::SEC_TO_MIDN;
            else
               x_in = req_data.seconds_in + j2k_cal_pkg::SEC_TO_MIDN;
         end
         j2k_cal_pkg::ST_SET: begin
            // a=l, b=n, c=y, d=m
            case (cnt_ff) inside
               6'd0, 6'd4, 6'd8, 6'd12, 6'd17, 6'd22, 6'd26, 6'd30: begin
                  mu_a = x_ff; mu_b = dv_rcp; quo_in = mu_p[63:32];
               end
               6'd1, 6'd5, 6'd9, 6'd13, 6'd18, 6'd23, 6'd27, 6'd31: begin
                  mu_a = quo_ff; mu_b = dv_den; rem_in = x_ff - mu_p[31:0];
               end
               6'd2, 6'd6, 6'd10, 6'd14, 6'd19, 6'd24, 6'd28, 6'd32: begin
                  if (rem_ff >= dv_den) begin
                     quo_in = quo_ff + 32'd1;
                     rem_in = rem_ff - dv_den;
                  end
               end
               6'd3: begin
                  a_in = quo_ff + j2k_cal_pkg::JD_Y2K + j2k_cal_pkg::JD_SHIFT;
                  x_in = rem_ff;
               end
               6'd7: begin
                  rsp_in.hour_out = quo_ff[4:0];
                  x_in = rem_ff;
               end
               6'd11: begin
                  rsp_in.minute_out = quo_ff[5:0];
                  rsp_in.second_out = rem_ff[5:0];
                  mu_a = a_ff; mu_b = 32'd4; x_in = mu_lo;
               end
               6'd15: begin
                  b_in = quo_ff;
                  mu_a = quo_ff; mu_b = j2k_cal_pkg::DIV_CYCLE; mu_c = 32'd3;
                  a_in = a_ff - {2'b00, mu_lo[31:2]};
               end
               6'd16: begin
                  mu_a = a_ff; mu_b = 32'd4000; mu_c = 32'd4000; x_in = mu_lo;
               end
               6'd20: begin
                  c_in = quo_ff;
                  mu_a = quo_ff; mu_b = 32'd1461;
                  a_in = a_ff - {2'b00, mu_lo[31:2]} + 32'd31;
               end
               6'd21: begin
                  mu_a = a_ff; mu_b = 32'd80; x_in = mu_lo;
               end
               6'd25: begin
                  d_in = quo_ff;
                  mu_a = quo_ff; mu_b = j2k_cal_pkg::DIV_MONTH; x_in = mu_lo;
               end
               6'd29: begin
                  rsp_in.day_out = 5'(a_ff - quo_ff);
                  x_in = d_ff;
               end
               6'd33: begin
                  a_in = quo_ff;
                  mu_a = quo_ff; mu_b = 32'd12; d_in = d_ff + 32'd2 - mu_lo;
               end
               6'd34: begin
                  mu_a = b_ff - 32'd49; mu_b = 32'd100; b_in = mu_lo;
               end
               default: begin
                  rsp_in.year_offset = 8'(b_ff + c_ff + a_ff - 32'd2000);
                  rsp_in.month_out   = d_ff[3:0];
                  rsp_in.ok = 1'b1;
                  valid_in  = 1'b1;
               end
            endcase
         end
         j2k_cal_pkg::ST_GET: begin
            // b=jd accumulator, c=seconds, d=scratch
            case (cnt_ff) inside
               6'd0: begin
                  mu_a = g_year + 32'd4800 - g_ycarry; mu_b = 32'd1461;
                  b_in = g_day - j2k_cal_pkg::JD_BASE + {2'b00, mu_lo[31:2]};
               end
               6'd1: begin
                  mu_a = g_mshift; mu_b = 32'd367; x_in = mu_lo;
               end
               6'd2, 6'd6: begin
                  mu_a = x_ff; mu_b = dv_rcp; quo_in = mu_p[63:32];
               end
               6'd3, 6'd7: begin
                  mu_a = quo_ff; mu_b = dv_den; rem_in = x_ff - mu_p[31:0];
               end
               6'd4, 6'd8: begin
                  if (rem_ff >= dv_den) begin
                     quo_in = quo_ff + 32'd1;
                     rem_in = rem_ff - dv_den;
                  end
               end
               6'd5: begin
                  b_in = b_ff + quo_ff;
                  x_in = g_year + 32'd4900 - g_ycarry;
               end
               6'd9: begin
                  mu_a = quo_ff; mu_b = 32'd3; b_in = b_ff - {2'b00, mu_lo[31:2]};
               end
               6'd10: begin
                  mu_a = b_ff - j2k_cal_pkg::JD_Y2K; mu_b = j2k_cal_pkg::SEC_PER_DAY;
                  c_in = mu_lo;
               end
               6'd11: begin
                  mu_a = g_hour; mu_b = 32'd60; mu_c = g_min; d_in = mu_lo;
               end
               6'd12: begin
                  mu_a = d_ff; mu_b = 32'd60; mu_c = g_sec - j2k_cal_pkg::SEC_TO_MIDN;
                  c_in = c_ff + mu_lo;
               end
               default: begin
                  rsp_in.ok = 1'b1;
                  rsp_in.seconds_out = c_ff;
                  rsp_in.nanoseconds_out = j2k_cal_pkg::NS_SHIFT;
               end
            endcase
         end
         default: cnt_in = 6'd0;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == j2k_cal_pkg::ST_IDLE);
      rsp_valid = (state_ff == j2k_cal_pkg::ST_DONE);
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= j2k_cal_pkg::ST_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      x_ff   <= x_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule
